// File: hdl/itkf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itkf_pkg: shared definitions for the IMU tilt Kalman fusion block
// Register indexes, reset values, action and status codes, and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package itkf_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_CAL_SAMPLES = 3'd0;
    localparam logic [2:0] REG_DEADBAND    = 3'd1;
    localparam logic [2:0] REG_TIME_STEP   = 3'd2;
    localparam logic [2:0] REG_PROC_INC    = 3'd3;
    localparam logic [2:0] REG_MEAS_VAR    = 3'd4;
    localparam logic [2:0] REG_INIT_UNC    = 3'd5;

    // Register reset values.
    localparam logic [15:0] RST_CAL_SAMPLES = 16'd2000;
    localparam logic [15:0] RST_DEADBAND    = 16'd256;
    localparam logic [15:0] RST_TIME_STEP   = 16'd262;
    localparam logic [31:0] RST_PROC_INC    = 32'd4194;
    localparam logic [31:0] RST_MEAS_VAR    = 32'd589824;
    localparam logic [31:0] RST_INIT_UNC    = 32'd262144;

    // Input actions.
    localparam logic [1:0] ACT_CAL_START  = 2'd0;
    localparam logic [1:0] ACT_CAL_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_MEASURE    = 2'd2;

    // Result status codes.
    localparam logic [1:0] STS_MEASURE  = 2'd0;
    localparam logic [1:0] STS_CAL_BUSY = 2'd1;
    localparam logic [1:0] STS_CAL_DONE = 2'd2;

    // Default number of CORDIC iterations.
    localparam int CORDIC_STEPS_DEF = 16;

    // Angle limits in 1/256 deg.
    localparam logic signed [17:0] ANGLE_MAX = 18'sd23040;

    // Arctangent of 2^-i in 1/65536 deg.
    function automatic logic [22:0] itkf_atan(input logic [4:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/imu_tilt_kalman_fusion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_kalman_fusion: gyro bias calibration and Kalman tilt estimation
// One inertial sample in, at most one result out. A sequencer drives one shared
// multiplier, a radix-2 divider, a bit-serial square root and a CORDIC stage.
// ----------------------------------------------------------------------------
// Usage:
// - Input stream: tuser carries the action, tdata the gyro rates and the
//   accelerations. A transfer is taken only while the block is idle.
// - Output stream: tuser carries the status, tdata the rates, the accel
//   angles, the filtered angles and their variances.
// - Configuration: a write on i_cfg_we updates the register at i_cfg_addr; the
//   user must write only while no sample is in flight; the block does not check.
// - Sequence: a start-calibration or ignored sample goes straight to the
//   output register, as does a plain calibration sample; the one that ends
//   calibration first runs the bias division (48 divider steps per axis).
//   A measurement runs the two square roots and CORDIC passes, then the
//   two Kalman updates, each dominated by the 48-step gain division, and
//   then loads the output register; a zero root skips its CORDIC pass and
//   a zero gain denominator skips its division. One sample is worked on at
//   a time.
// - Reset loads all registers with their defaults, clears bias and estimates
//   and loads the variances with the default initial uncertainty.
// - When the receiver stalls, the result holds in the output register; the
//   next sample is still accepted and waits at its end for that register.
// ----------------------------------------------------------------------------
module imu_tilt_kalman_fusion #(
    parameter int CORDIC_STEPS = itkf_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: gyro_pitch_rate[20:0], gyro_roll_rate[41:21], gyro_yaw_rate[62:42],
    //        accel_x[79:63], accel_y[96:80], accel_z[113:97], zero fill
    input  logic [119:0] i_s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: pitch_rate[21:0], roll_rate[43:22], yaw_rate[65:44],
    //        accel_pitch_angle[81:66], accel_roll_angle[97:82],
    //        filtered_pitch[121:98], filtered_roll[145:122],
    //        pitch_variance[177:146], roll_variance[209:178], zero fill
    output logic [215:0] o_m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]   o_m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data
);
    import itkf_pkg::*;

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int DIV_STEPS = 48;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_BDIV  = 17'h00002,
        S_BWAIT = 17'h00004,
        S_BSET  = 17'h00008,
        S_SQB   = 17'h00010,
        S_SQC   = 17'h00020,
        S_SQI   = 17'h00040,
        S_SQRT  = 17'h00080,
        S_CORD  = 17'h00100,
        S_ANG   = 17'h00200,
        S_KMUL  = 17'h00400,
        S_KGAIN = 17'h00800,
        S_KDIV  = 17'h01000,
        S_KDIFF = 17'h02000,
        S_KCOR  = 17'h04000,
        S_KVAR  = 17'h08000,
        S_DONE  = 17'h10000
    } t_state;

    // Configuration registers.
    logic [15:0] r_cal_samples, r_deadband, r_tstep;
    logic [31:0] r_proc_inc, r_meas_var, r_init_unc;

    // Filter and calibration state.
    logic signed [20:0] r_bias [3];
    logic signed [36:0] r_bsum [3];
    logic [15:0]        r_cnt;
    logic               r_calib;
    logic signed [23:0] r_est [2];
    logic [31:0]        r_var [2];

    // Work registers.
    t_state             r_state;
    logic signed [16:0] r_acc [3];
    logic signed [21:0] r_rate [3];
    logic signed [15:0] r_ang [2];
    logic               r_ax;
    logic [1:0]         r_bi;
    logic signed [58:0] r_prod;
    logic [33:0]        r_sqa, r_sq_n, r_sq_root, r_sq_bit;
    logic signed [33:0] r_cx, r_cy;
    logic signed [25:0] r_cz;
    logic [CW-1:0]      r_ci;
    logic [47:0]        r_dv_q;
    logic [32:0]        r_dv_rem, r_dv_den;
    logic [5:0]         r_dv_i;
    logic [31:0]        r_kp;
    logic signed [23:0] r_ke;
    logic [16:0]        r_gain;
    logic [1:0]         r_status;
    logic               r_out_valid;
    logic [215:0]       r_out_data;
    logic [1:0]         r_out_user;

    // Saturate to the 24-bit angle range.
    function automatic logic signed [23:0] sat24(input logic signed [59:0] v);
        logic signed [23:0] res;
        if (v > 60'sd8388607) begin
            res = 24'sh7FFFFF;
        end else if (v < -60'sd8388608) begin
            res = 24'sh800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    // Input field views.
    logic signed [20:0] in_raw [3];
    logic signed [16:0] in_acc [3];
    assign in_raw[0] = i_s_axis_tdata[20:0];
    assign in_raw[1] = i_s_axis_tdata[41:21];
    assign in_raw[2] = i_s_axis_tdata[62:42];
    assign in_acc[0] = i_s_axis_tdata[79:63];
    assign in_acc[1] = i_s_axis_tdata[96:80];
    assign in_acc[2] = i_s_axis_tdata[113:97];

    logic in_xfer;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // Bias-corrected, deadbanded rates.
    logic signed [21:0] in_rate [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [21:0] d;
            logic [21:0]        m;
            d = 22'(in_raw[k]) - 22'(r_bias[k]);
            m = d[21] ? 22'(-d) : 22'(d);
            in_rate[k] = (m <= {6'd0, r_deadband}) ? 22'sd0 : d;
        end
    end

    // Calibration count after this sample.
    logic [15:0] cnt_inc;
    assign cnt_inc = r_cnt + 16'd1;

    // Operand selection for the angle in work: pitch uses y over x, z;
    // roll uses x over y, z.
    logic signed [16:0] sel_a, sel_b;
    assign sel_a = r_ax ? r_acc[0] : r_acc[1];
    assign sel_b = r_ax ? r_acc[1] : r_acc[0];

    // Shared multiplier with registered product.
    logic signed [32:0] m_a;
    logic signed [25:0] m_b;
    logic signed [24:0] k_diff;
    logic signed [58:0] n_prod;
    assign k_diff = 25'(r_ang[r_ax]) - 25'(r_ke);
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_SQB: begin
                m_a = 33'(sel_b);
                m_b = 26'(sel_b);
            end
            S_SQC: begin
                m_a = 33'(r_acc[2]);
                m_b = 26'(r_acc[2]);
            end
            S_KMUL: begin
                m_a = $signed({17'd0, r_tstep});
                m_b = 26'(r_rate[r_ax]);
            end
            S_KDIFF: begin
                m_a = $signed({16'd0, r_gain});
                m_b = 26'(k_diff);
            end
            S_KCOR: begin
                m_a = $signed({1'b0, r_kp});
                m_b = $signed({9'd0, 17'(17'h10000 - r_gain)});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end
    assign n_prod = m_a * m_b;

    // Product rounded half up by 2^16.
    logic signed [58:0] prod_rnd;
    assign prod_rnd = (r_prod + 59'sd32768) >>> 16;

    // One restoring divider step.
    logic [33:0] dv_sh;
    logic        dv_ge;
    logic [32:0] n_dv_rem;
    logic [47:0] n_dv_q;
    assign dv_sh    = {r_dv_rem, r_dv_q[47]};
    assign dv_ge    = dv_sh >= {1'b0, r_dv_den};
    assign n_dv_rem = dv_ge ? 33'(dv_sh - {1'b0, r_dv_den}) : dv_sh[32:0];
    assign n_dv_q   = {r_dv_q[46:0], dv_ge};

    // One square root step.
    logic [33:0] sq_t;
    logic        sq_ge;
    assign sq_t  = r_sq_root + r_sq_bit;
    assign sq_ge = r_sq_n >= sq_t;

    // One CORDIC vectoring step.
    logic signed [33:0] c_dx, c_dy;
    logic signed [25:0] c_at;
    assign c_dx = r_cy >>> r_ci;
    assign c_dy = r_cx >>> r_ci;
    assign c_at = $signed({3'd0, itkf_atan(5'(r_ci))});

    // Final angle: round, clamp, negate for roll.
    logic signed [17:0] ang_rnd, ang_clp;
    assign ang_rnd = 18'((r_cz + 26'sd128) >>> 8);
    assign ang_clp = (ang_rnd > ANGLE_MAX) ? ANGLE_MAX :
                     ((ang_rnd < -ANGLE_MAX) ? -ANGLE_MAX : ang_rnd);

    // Bias division operands for the axis in work.
    logic signed [36:0] b_sum;
    logic [36:0]        b_mag;
    logic [15:0]        b_n;
    assign b_sum = r_bsum[r_bi];
    assign b_mag = b_sum[36] ? 37'(-b_sum) : 37'(b_sum);
    assign b_n   = (r_cnt == 16'd0) ? 16'd1 : r_cnt;

    // Kalman helpers.
    logic [32:0] kp_sum, k_den;
    assign kp_sum = {1'b0, r_var[r_ax]} + {1'b0, r_proc_inc};
    assign k_den  = {1'b0, r_kp} + {1'b0, r_meas_var};

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_samples <= RST_CAL_SAMPLES;
            r_deadband    <= RST_DEADBAND;
            r_tstep       <= RST_TIME_STEP;
            r_proc_inc    <= RST_PROC_INC;
            r_meas_var    <= RST_MEAS_VAR;
            r_init_unc    <= RST_INIT_UNC;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CAL_SAMPLES: r_cal_samples <= i_cfg_data[15:0];
                REG_DEADBAND:    r_deadband    <= i_cfg_data[15:0];
                REG_TIME_STEP:   r_tstep       <= i_cfg_data[15:0];
                REG_PROC_INC:    r_proc_inc    <= i_cfg_data;
                REG_MEAS_VAR:    r_meas_var    <= i_cfg_data;
                REG_INIT_UNC:    r_init_unc    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Multiplier output register.
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_calib     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_bias[k] <= '0;
                r_bsum[k] <= '0;
            end
            for (int k = 0; k < 2; k++) begin
                r_est[k] <= '0;
                r_var[k] <= RST_INIT_UNC;
            end
        end else begin
            // A transfer empties the output register unless a new result
            // is loaded in the same cycle.
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (i_s_axis_tuser)
                            ACT_CAL_START: begin
                                for (int k = 0; k < 3; k++) begin
                                    r_bsum[k] <= '0;
                                end
                                r_cnt    <= '0;
                                r_calib  <= 1'b1;
                                r_var[0] <= r_init_unc;
                                r_var[1] <= r_init_unc;
                                r_status <= STS_CAL_BUSY;
                                r_state  <= S_DONE;
                            end
                            ACT_CAL_SAMPLE: begin
                                if (!r_calib) begin
                                    r_status <= STS_CAL_DONE;
                                    r_state  <= S_DONE;
                                end else begin
                                    for (int k = 0; k < 3; k++) begin
                                        r_bsum[k] <= r_bsum[k] + 37'(in_raw[k]);
                                    end
                                    r_cnt <= cnt_inc;
                                    if (cnt_inc >= r_cal_samples) begin
                                        r_status <= STS_CAL_DONE;
                                        r_bi     <= 2'd0;
                                        r_state  <= S_BDIV;
                                    end else begin
                                        r_status <= STS_CAL_BUSY;
                                        r_state  <= S_DONE;
                                    end
                                end
                            end
                            ACT_MEASURE: begin
                                for (int k = 0; k < 3; k++) begin
                                    r_rate[k] <= in_rate[k];
                                    r_acc[k]  <= in_acc[k];
                                end
                                r_ax     <= 1'b0;
                                r_status <= STS_MEASURE;
                                r_state  <= S_SQB;
                            end
                            default: ;
                        endcase
                    end
                end

                // Bias average per axis, rounded away from zero on ties.
                S_BDIV: begin
                    r_dv_q   <= 48'(b_mag) + 48'(b_n >> 1);
                    r_dv_den <= 33'(b_n);
                    r_dv_rem <= '0;
                    r_dv_i   <= '0;
                    r_state  <= S_BWAIT;
                end
                S_BWAIT: begin
                    r_dv_q   <= n_dv_q;
                    r_dv_rem <= n_dv_rem;
                    r_dv_i   <= r_dv_i + 6'd1;
                    if (r_dv_i == 6'(DIV_STEPS - 1)) begin
                        r_state <= S_BSET;
                    end
                end
                S_BSET: begin
                    r_bias[r_bi] <= b_sum[36] ? 21'(-r_dv_q[20:0]) : r_dv_q[20:0];
                    if (r_bi == 2'd2) begin
                        r_calib <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_bi    <= r_bi + 2'd1;
                        r_state <= S_BDIV;
                    end
                end

                // Squares of the two side components.
                S_SQB: begin
                    r_state <= S_SQC;
                end
                S_SQC: begin
                    r_sqa   <= r_prod[33:0];
                    r_state <= S_SQI;
                end
                S_SQI: begin
                    r_sq_n    <= r_sqa + r_prod[33:0];
                    r_sq_root <= '0;
                    r_sq_bit  <= 34'h1_0000_0000;
                    r_state   <= S_SQRT;
                end

                // Integer square root, two bits of the radicand per cycle.
                S_SQRT: begin
                    if (r_sq_bit != 34'd0) begin
                        if (sq_ge) begin
                            r_sq_n    <= r_sq_n - sq_t;
                            r_sq_root <= (r_sq_root >> 1) + r_sq_bit;
                        end else begin
                            r_sq_root <= r_sq_root >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end else if (r_sq_root == 34'd0) begin
                        // Zero root: the angle is pinned to the signed limit, or to zero when sel_a is zero.
                        if (sel_a == 17'sd0) begin
                            r_cz <= '0;
                        end else if (sel_a > 17'sd0) begin
                            r_cz <= 26'sd5898240;
                        end else begin
                            r_cz <= -26'sd5898240;
                        end
                        r_state <= S_ANG;
                    end else begin
                        r_cx    <= $signed({r_sq_root[21:0], 12'd0});
                        r_cy    <= $signed({{5{sel_a[16]}}, sel_a, 12'd0});
                        r_cz    <= '0;
                        r_ci    <= '0;
                        r_state <= S_CORD;
                    end
                end

                // CORDIC vectoring iterations.
                S_CORD: begin
                    if (r_cy > 34'sd0) begin
                        r_cx <= r_cx + c_dx;
                        r_cy <= r_cy - c_dy;
                        r_cz <= r_cz + c_at;
                    end else begin
                        r_cx <= r_cx - c_dx;
                        r_cy <= r_cy + c_dy;
                        r_cz <= r_cz - c_at;
                    end
                    r_ci <= r_ci + CW'(1);
                    if (r_ci == CW'(CORDIC_STEPS - 1)) begin
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    r_ang[r_ax] <= r_ax ? 16'(-ang_clp) : 16'(ang_clp);
                    if (!r_ax) begin
                        r_ax    <= 1'b1;
                        r_state <= S_SQB;
                    end else begin
                        r_ax    <= 1'b0;
                        r_state <= S_KMUL;
                    end
                end

                // Kalman predict: rate product issued, variance grown.
                S_KMUL: begin
                    r_kp    <= kp_sum[32] ? 32'hFFFF_FFFF : kp_sum[31:0];
                    r_state <= S_KGAIN;
                end
                S_KGAIN: begin
                    r_ke <= sat24(60'(r_est[r_ax]) + 60'(prod_rnd));
                    if (k_den == 33'd0) begin
                        r_gain  <= '0;
                        r_state <= S_KDIFF;
                    end else begin
                        r_dv_q   <= {r_kp, 16'd0};
                        r_dv_den <= k_den;
                        r_dv_rem <= '0;
                        r_dv_i   <= '0;
                        r_state  <= S_KDIV;
                    end
                end
                S_KDIV: begin
                    r_dv_q   <= n_dv_q;
                    r_dv_rem <= n_dv_rem;
                    r_dv_i   <= r_dv_i + 6'd1;
                    if (r_dv_i == 6'(DIV_STEPS - 1)) begin
                        r_gain  <= n_dv_q[16:0];
                        r_state <= S_KDIFF;
                    end
                end
                S_KDIFF: begin
                    r_state <= S_KCOR;
                end
                S_KCOR: begin
                    r_ke    <= sat24(60'(r_ke) + 60'(prod_rnd));
                    r_state <= S_KVAR;
                end
                S_KVAR: begin
                    r_est[r_ax] <= r_ke;
                    r_var[r_ax] <= r_prod[47:16];
                    if (!r_ax) begin
                        r_ax    <= 1'b1;
                        r_state <= S_KMUL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end

                // Hand the result to the output register.
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_status;
                        if (r_status == STS_MEASURE) begin
                            r_out_data <= {6'd0, r_var[1], r_var[0], r_est[1], r_est[0],
                                           r_ang[1], r_ang[0], r_rate[2], r_rate[1],
                                           r_rate[0]};
                        end else begin
                            r_out_data <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

// File: tb/tb_imu_tilt_kalman_fusion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_tilt_kalman_fusion: self-checking bench for the tilt Kalman block
// Drives calibration and measurement samples over the input stream with
// random gaps, predicts every result with an independent fixed-point model of
// the bias, deadband, CORDIC tilt and Kalman filter, and checks the output
// stream field by field. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb_imu_tilt_kalman_fusion;
    import itkf_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 400;

    // Reserved action code that the block drops without a result.
    localparam logic [1:0] ACT_NONE = 2'd3;

    // One expected result.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [21:0] pitch_rate;
        logic signed [21:0] roll_rate;
        logic signed [21:0] yaw_rate;
        logic signed [15:0] acc_pitch;
        logic signed [15:0] acc_roll;
        logic signed [23:0] filt_pitch;
        logic signed [23:0] filt_roll;
        logic [31:0]        var_pitch;
        logic [31:0]        var_roll;
    } t_tilt_result;

    // One directed stimulus row; has_exp marks a hand-written expectation.
    typedef struct {
        logic [1:0]         act;
        logic signed [20:0] gyro [3];
        logic signed [16:0] acc [3];
        bit                 has_exp;
        t_tilt_result       exp_res;
    } t_sample_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [215:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_data = '0;

    imu_tilt_kalman_fusion i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_data     (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Predictor copy of the registers and the filter state.
    logic [15:0]        cal_count_reg, deadband_reg, dt_reg;
    logic [31:0]        q_reg, r_reg, p0_reg;
    logic signed [20:0] bias [3];
    logic signed [36:0] bias_acc [3];
    logic [15:0]        cal_seen;
    bit                 cal_active;
    logic signed [23:0] est [2];
    logic [31:0]        est_var [2];

    t_tilt_result pending_results [$];
    int  error_count = 0;
    int  cycle_count = 0;
    int  n_sent = 0, n_checked = 0, n_meas = 0, n_cal_done = 0;
    bit  stall_long = 1'b0;

    function automatic longint shr_floor(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint shr_round(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint n);
        longint root, bitv;
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Arctangent of a over the root of b^2 + c^2, in 1/256 degree.
    function automatic longint tilt_angle(longint a, longint b, longint c);
        longint atan_deg [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                  58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                  229, 115};
        longint r, x, y, z, dx, dy;
        r = int_sqrt(b * b + c * c);
        if (r == 0) return a > 0 ? 23040 : (a < 0 ? -23040 : 0);
        x = r * 4096;
        y = a * 4096;
        z = 0;
        for (int i = 0; i < 16; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_deg[i];
            end else begin
                x -= dx; y += dy; z -= atan_deg[i];
            end
        end
        return limit(shr_round(z, 8), -23040, 23040);
    endfunction

    // One predict, gain and correct pass of an angle filter.
    function automatic void filter_update(int k, longint rate, longint meas);
        longint e, p, den, gain;
        e = est[k];
        p = longint'(est_var[k]) + longint'(q_reg);
        e = limit(e + shr_round(rate * longint'(dt_reg), 16), -8388608, 8388607);
        if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
        den = p + longint'(r_reg);
        gain = den == 0 ? 0 : (p << 16) / den;
        e = limit(e + shr_round(gain * (meas - e), 16), -8388608, 8388607);
        p = ((65536 - gain) * p) >> 16;
        est[k] = e[23:0];
        est_var[k] = p[31:0];
    endfunction

    task automatic predictor_reset();
        cal_count_reg = RST_CAL_SAMPLES;
        deadband_reg = RST_DEADBAND;
        dt_reg = RST_TIME_STEP;
        q_reg = RST_PROC_INC;
        r_reg = RST_MEAS_VAR;
        p0_reg = RST_INIT_UNC;
        for (int i = 0; i < 3; i++) begin
            bias[i] = '0;
            bias_acc[i] = '0;
        end
        cal_seen = '0;
        cal_active = 1'b0;
        for (int i = 0; i < 2; i++) begin
            est[i] = '0;
            est_var[i] = RST_INIT_UNC;
        end
    endtask

    // Work out the result of one accepted sample; returns 0 if none is due.
    function automatic bit predict_tilt(input logic [1:0] act,
                                        input logic signed [20:0] gyro [3],
                                        input logic signed [16:0] acc [3],
                                        output t_tilt_result res);
        longint d, n, s, mag, q, pitch, roll;
        longint rate [3];
        res = '0;
        if (act == ACT_NONE) return 1'b0;
        if (act == ACT_CAL_START) begin
            for (int i = 0; i < 3; i++) bias_acc[i] = '0;
            cal_seen = '0;
            cal_active = 1'b1;
            est_var[0] = p0_reg;
            est_var[1] = p0_reg;
            res.status = STS_CAL_BUSY;
            return 1'b1;
        end
        if (act == ACT_CAL_SAMPLE) begin
            res.status = STS_CAL_DONE;
            if (!cal_active) return 1'b1;
            for (int i = 0; i < 3; i++) bias_acc[i] = bias_acc[i] + 37'(gyro[i]);
            cal_seen = cal_seen + 16'd1;
            if (cal_seen >= cal_count_reg) begin
                n = cal_seen == 0 ? 1 : longint'(cal_seen);
                for (int i = 0; i < 3; i++) begin
                    s = bias_acc[i];
                    mag = s < 0 ? -s : s;
                    q = (mag + n / 2) / n;
                    bias[i] = 21'(s < 0 ? -q : q);
                end
                cal_active = 1'b0;
                n_cal_done++;
            end else begin
                res.status = STS_CAL_BUSY;
            end
            return 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            d = longint'(gyro[i]) - longint'(bias[i]);
            rate[i] = (d < 0 ? -d : d) <= longint'(deadband_reg) ? 0 : d;
        end
        pitch = tilt_angle(acc[1], acc[0], acc[2]);
        roll = -tilt_angle(acc[0], acc[1], acc[2]);
        filter_update(0, rate[0], pitch);
        filter_update(1, rate[1], roll);
        res.status = STS_MEASURE;
        res.pitch_rate = 22'(rate[0]);
        res.roll_rate = 22'(rate[1]);
        res.yaw_rate = 22'(rate[2]);
        res.acc_pitch = 16'(pitch);
        res.acc_roll = 16'(roll);
        res.filt_pitch = est[0];
        res.filt_roll = est[1];
        res.var_pitch = est_var[0];
        res.var_roll = est_var[1];
        n_meas++;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        error_count++;
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 n_checked, field, got, want);
    endtask

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Output checker: compare each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_tilt_result want, got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.pitch_rate = m_tdata[21:0];
            got.roll_rate = m_tdata[43:22];
            got.yaw_rate = m_tdata[65:44];
            got.acc_pitch = m_tdata[81:66];
            got.acc_roll = m_tdata[97:82];
            got.filt_pitch = m_tdata[121:98];
            got.filt_roll = m_tdata[145:122];
            got.var_pitch = m_tdata[177:146];
            got.var_roll = m_tdata[209:178];
            if (pending_results.size() == 0) begin
                error_count++;
                $display("Unexpected result with status %0d", m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.pitch_rate !== want.pitch_rate)
                    report_mismatch("pitch_rate", got.pitch_rate, want.pitch_rate);
                if (got.roll_rate !== want.roll_rate)
                    report_mismatch("roll_rate", got.roll_rate, want.roll_rate);
                if (got.yaw_rate !== want.yaw_rate)
                    report_mismatch("yaw_rate", got.yaw_rate, want.yaw_rate);
                if (got.acc_pitch !== want.acc_pitch)
                    report_mismatch("accel_pitch", got.acc_pitch, want.acc_pitch);
                if (got.acc_roll !== want.acc_roll)
                    report_mismatch("accel_roll", got.acc_roll, want.acc_roll);
                if (got.filt_pitch !== want.filt_pitch)
                    report_mismatch("filtered_pitch", got.filt_pitch, want.filt_pitch);
                if (got.filt_roll !== want.filt_roll)
                    report_mismatch("filtered_roll", got.filt_roll, want.filt_roll);
                if (got.var_pitch !== want.var_pitch)
                    report_mismatch("pitch_variance", got.var_pitch, want.var_pitch);
                if (got.var_roll !== want.var_roll)
                    report_mismatch("roll_variance", got.var_roll, want.var_roll);
            end
            n_checked++;
        end
    end

    // Receiver: random stall per result, plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_rst_n);
        while (1) begin
            @(negedge i_clk);
            if (stall_long) begin
                m_tready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                stall_long = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_tvalid && m_tready));
        end
    end

    // Offer one sample, wait for its transfer, then predict its result.
    task automatic send_sample(input logic [1:0] act,
                               input logic signed [20:0] gyro [3],
                               input logic signed [16:0] acc [3],
                               input bit has_exp, input t_tilt_result exp_res,
                               input bit no_gaps);
        t_tilt_result res;
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {6'd0, acc[2], acc[1], acc[0], gyro[2], gyro[1], gyro[0]};
        do @(posedge i_clk); while (!s_tready);
        if (predict_tilt(act, gyro, acc, res)) begin
            if (has_exp && res !== exp_res) begin
                error_count++;
                $display("Predictor disagrees with directed row %0d", n_sent);
            end
            pending_results.push_back(res);
        end
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (addr)
            REG_CAL_SAMPLES: cal_count_reg = value[15:0];
            REG_DEADBAND:    deadband_reg = value[15:0];
            REG_TIME_STEP:   dt_reg = value[15:0];
            REG_PROC_INC:    q_reg = value;
            REG_MEAS_VAR:    r_reg = value;
            REG_INIT_UNC:    p0_reg = value;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [20:0] rand_gyro(bit narrow);
        case ($urandom_range(0, 5))
            0: return narrow ? 21'sd0 : 21'sh0FFFFF;
            1: return narrow ? 21'sd0 : 21'sh100000;
            2, 3: return 21'($urandom_range(0, 4000) - 2000);
            default: return narrow ? 21'($urandom_range(0, 8000) - 4000) : 21'($urandom);
        endcase
    endfunction

    function automatic logic signed [16:0] rand_accel();
        case ($urandom_range(0, 7))
            0: return 17'sh0FFFF;
            1: return 17'sh10000;
            2: return 17'sd0;
            3, 4: return 17'($urandom_range(0, 9000) - 4500);
            default: return 17'($urandom);
        endcase
    endfunction

    // Random phase: well-formed calibrations, measurements and some noise.
    task automatic random_phase(int n_items);
        logic signed [20:0] g [3];
        logic signed [16:0] a [3];
        logic [1:0] act;
        int pick;
        t_tilt_result none;
        none = '0;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) act = ACT_CAL_START;
            else if (pick < 22) act = cal_active || pick < 8 ? ACT_CAL_SAMPLE : ACT_MEASURE;
            else if (pick < 25) act = ACT_NONE;
            else act = cal_active && pick < 60 ? ACT_CAL_SAMPLE : ACT_MEASURE;
            for (int i = 0; i < 3; i++) begin
                g[i] = rand_gyro(act == ACT_CAL_SAMPLE);
                a[i] = rand_accel();
            end
            send_sample(act, g, a, 1'b0, none, $urandom_range(0, 9) < 3);
        end
    endtask

    // Directed table, register phases and random traffic.
    initial begin
        t_sample_row rows [$];
        t_sample_row row;
        t_tilt_result busy, done;
        logic [31:0] cal_n [4];
        cal_n = '{32'd1, 32'd0, 32'd4, 32'd65535};
        predictor_reset();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        busy = '0; busy.status = STS_CAL_BUSY;
        done = '0; done.status = STS_CAL_DONE;
        // Calibration sample outside a calibration is ignored.
        row = '{ACT_CAL_SAMPLE, '{21'sd5, 21'sd6, 21'sd7}, '{17'sd0, 17'sd0, 17'sd0},
                1'b1, done};
        rows.push_back(row);
        // All-zero acceleration and zero root with positive and negative a.
        row = '{ACT_MEASURE, '{21'sd0, 21'sd0, 21'sd0}, '{17'sd0, 17'sd0, 17'sd0},
                1'b0, busy};
        rows.push_back(row);
        row.acc = '{17'sd0, 17'sd4096, 17'sd0}; rows.push_back(row);
        row.acc = '{17'sd0, -17'sd4096, 17'sd0}; rows.push_back(row);
        row.acc = '{17'sh0FFFF, 17'sd0, 17'sd0}; rows.push_back(row);
        row.acc = '{17'sh10000, 17'sh10000, 17'sh10000}; rows.push_back(row);
        row.acc = '{17'sh0FFFF, 17'sh0FFFF, 17'sh0FFFF}; rows.push_back(row);
        // Rate extremes around the deadband.
        row.gyro = '{21'sd256, -21'sd256, 21'sd257}; row.acc = '{17'sd0, 17'sd0, 17'sd4096};
        rows.push_back(row);
        row.gyro = '{21'sh0FFFFF, 21'sh100000, -21'sd257}; rows.push_back(row);
        // Calibration start, one sample, an ignored action, a measurement and a further sample.
        row = '{ACT_CAL_START, '{21'sd1, 21'sd1, 21'sd1}, '{17'sd1, 17'sd1, 17'sd1},
                1'b1, busy};
        rows.push_back(row);
        row.act = ACT_CAL_SAMPLE;
        row.gyro = '{21'sh0FFFFF, 21'sh100000, -21'sd3}; rows.push_back(row);
        row.act = ACT_NONE; row.has_exp = 1'b0; rows.push_back(row);
        row.act = ACT_MEASURE;
        row.gyro = '{21'sd900, -21'sd900, 21'sd10}; row.acc = '{17'sd1000, -17'sd2000, 17'sd3000};
        rows.push_back(row);
        row.act = ACT_CAL_SAMPLE; row.has_exp = 1'b1;
        row.gyro = '{-21'sd1, 21'sd2, 21'sd0}; rows.push_back(row);

        foreach (rows[k])
            send_sample(rows[k].act, rows[k].gyro, rows[k].acc, rows[k].has_exp,
                        rows[k].exp_res, 1'b0);
        wait_idle();

        // Phase sweep over register settings, extremes included.
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_CAL_SAMPLES, ph == 3 ? 32'd3 : cal_n[ph]);
            write_reg(REG_DEADBAND, ph == 0 ? 32'd0 : (ph == 1 ? 32'd65535 : $urandom_range(0, 600)));
            write_reg(REG_TIME_STEP, ph == 0 ? 32'd65535 : (ph == 1 ? 32'd0 : $urandom_range(0, 2000)));
            write_reg(REG_PROC_INC, ph == 0 ? 32'hFFFF_FFFF : (ph == 1 ? 32'd0 : $urandom_range(0, 100000)));
            write_reg(REG_MEAS_VAR, ph == 1 ? 32'd0 : (ph == 2 ? 32'hFFFF_FFFF : $urandom));
            write_reg(REG_INIT_UNC, ph == 1 ? 32'd0 : (ph == 0 ? 32'hFFFF_FFFF : $urandom));
            if (ph == 2) stall_long = 1'b1;
            random_phase(ph == 3 ? 600 : 390);
            wait_idle();
        end
        // Random traffic with the calibration count at its largest value.
        write_reg(REG_CAL_SAMPLES, 32'd65535);
        random_phase(10);
        wait_idle();

        $display("Sent %0d samples, checked %0d results: %0d measurements, %0d calibrations",
                 n_sent, n_checked, n_meas, n_cal_done);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/itkf_pkg.sv
hdl/imu_tilt_kalman_fusion.sv
tb/tb_imu_tilt_kalman_fusion.sv
